// ----- hw/rtl/srecp_pkg.sv -----
// Shared types, character codes and helpers for the S-record character parser.
package srecp_pkg;

    typedef enum logic [2:0] {
        PH_START,
        PH_TYPE,
        PH_COUNT_HI,
        PH_COUNT_LO,
        PH_BODY,
        PH_EOL
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ABORT = 2'd2
    } t_kind;

    typedef enum logic {
        ACT_CHAR    = 1'b0,
        ACT_RESTART = 1'b1
    } t_action;

    localparam logic [7:0] CH_S  = 8'h53;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_A  = 8'h41;
    localparam logic [7:0] CH_F  = 8'h46;

    localparam logic [3:0] TYPE_HEADER = 4'd0;
    localparam logic [3:0] TYPE_RSVD   = 4'd4;
    localparam logic [3:0] TYPE_LAST_DATA = 4'd3;

    // Bit 4 set marks a character that is not an uppercase hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
            return d[4:0];
        end
        if (c >= CH_A && c <= CH_F) begin
            d = c - CH_A + 8'd10;
            return d[4:0];
        end
        return 5'h10;
    endfunction

    function automatic logic [2:0] addr_bytes(input logic [3:0] t);
        if (t == 4'd2 || t == 4'd6 || t == 4'd8)
            return 3'd3;
        if (t == 4'd3 || t == 4'd7)
            return 3'd4;
        return 3'd2;
    endfunction

endpackage

// ----- hw/rtl/srecord_char_stream_parser_core.sv -----
// S-record character parser: per-character state update into a result register.
//
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_action, i_char_code
//  out     | output    | o_out_valid / i_out_ready  | o_kind .. o_checksum_matches
//
// One character per cycle; the parser state and the result register are
// updated in the cycle the transfer happens, the result shows in the next cycle.
// The rate is set by the single result register: a new character is taken
// whenever that register is empty or being drained in the same cycle.
// Reset (synchronous, active low) and a restart item both return the parser
// to the line start with the abort flag clear. A stalled output stalls input.
module srecord_char_stream_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [7:0]  i_char_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_record_type,
    output logic [31:0] o_record_address,
    output logic [7:0]  o_byte_offset,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_checksum_value,
    output logic        o_checksum_readable,
    output logic        o_checksum_matches
);
    import srecp_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_aborted, n_aborted;
    logic [3:0]  r_type, n_type;
    logic [8:0]  r_chars_left, n_chars_left;
    logic [31:0] r_addr, n_addr;
    logic        r_dropped, n_dropped;
    logic [3:0]  r_high, n_high;
    logic        r_nibble_bad, n_nibble_bad;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_data_idx, n_data_idx;
    logic [7:0]  r_byte_count, n_byte_count;

    logic        r_out_valid;
    t_kind       r_kind, n_kind;
    logic [3:0]  r_o_type;
    logic [31:0] r_o_addr;
    logic [7:0]  r_o_offset, n_o_offset;
    logic [7:0]  r_o_data, n_o_data;
    logic [7:0]  r_o_cs, n_o_cs;
    logic        r_o_rd, n_o_rd;
    logic        r_o_mt, n_o_mt;
    logic        n_emit;

    logic        w_fire;
    logic [4:0]  w_hex;
    logic        w_pair_valid;
    logic [7:0]  w_pair_byte;
    logic [7:0]  w_byte_idx;
    logic [2:0]  w_addr_len;
    logic [31:0] w_new_addr;
    logic [7:0]  w_sum_plus;

    assign o_in_ready   = !r_out_valid || i_out_ready;
    assign w_fire       = i_in_valid && o_in_ready;
    assign w_hex        = hex_value(i_char_code);
    assign w_pair_valid = !r_nibble_bad && !w_hex[4];
    assign w_pair_byte  = {r_high, w_hex[3:0]};
    // Odd chars_left marks the second digit of a pair; byte index within the body.
    assign w_byte_idx   = r_byte_count - r_chars_left[8:1] - 8'd1;
    assign w_addr_len   = addr_bytes(r_type);
    assign w_new_addr   = {r_addr[23:0], w_pair_byte};
    assign w_sum_plus   = r_sum + w_pair_byte;

    always_comb begin
        n_phase      = r_phase;
        n_aborted    = r_aborted;
        n_type       = r_type;
        n_chars_left = r_chars_left;
        n_addr       = r_addr;
        n_dropped    = r_dropped;
        n_high       = r_high;
        n_nibble_bad = r_nibble_bad;
        n_sum        = r_sum;
        n_data_idx   = r_data_idx;
        n_byte_count = r_byte_count;
        n_emit       = 1'b0;
        n_kind       = KIND_ABORT;
        n_o_offset   = 8'd0;
        n_o_data     = 8'd0;
        n_o_cs       = 8'd0;
        n_o_rd       = 1'b0;
        n_o_mt       = 1'b0;

        if (w_fire) begin
            if (i_action == ACT_RESTART) begin
                n_phase      = PH_START;
                n_aborted    = 1'b0;
                n_type       = 4'd0;
                n_chars_left = 9'd0;
                n_addr       = 32'd0;
                n_dropped    = 1'b0;
                n_high       = 4'd0;
                n_nibble_bad = 1'b0;
                n_sum        = 8'd0;
                n_data_idx   = 8'd0;
                n_byte_count = 8'd0;
            end else if (!r_aborted) begin
                unique case (r_phase)
                    PH_START: begin
                        if (i_char_code != CH_S) begin
                            n_aborted = 1'b1;
                            n_emit    = 1'b1;
                        end else begin
                            n_addr     = 32'd0;
                            n_dropped  = 1'b0;
                            n_sum      = 8'd0;
                            n_data_idx = 8'd0;
                            n_type     = 4'd0;
                            n_phase    = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        if (i_char_code < CH_0 || i_char_code > CH_9) begin
                            n_aborted = 1'b1;
                            n_emit    = 1'b1;
                        end else begin
                            n_type  = w_hex[3:0];
                            n_phase = PH_COUNT_HI;
                        end
                    end
                    PH_COUNT_HI: begin
                        if (w_hex[4]) begin
                            n_aborted = 1'b1;
                            n_emit    = 1'b1;
                        end else begin
                            n_high  = w_hex[3:0];
                            n_phase = PH_COUNT_LO;
                        end
                    end
                    PH_COUNT_LO: begin
                        if (w_hex[4]) begin
                            n_aborted = 1'b1;
                            n_emit    = 1'b1;
                        end else begin
                            n_byte_count = w_pair_byte;
                            n_sum        = w_pair_byte;
                            n_chars_left = {w_pair_byte, 1'b0};
                            if (r_type == TYPE_RSVD || w_pair_byte <= {5'd0, w_addr_len})
                                n_dropped = 1'b1;
                            n_phase = (w_pair_byte == 8'd0) ? PH_EOL : PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        if (i_char_code == CH_NL) begin
                            n_aborted = 1'b1;
                            n_emit    = 1'b1;
                        end else begin
                            if (!r_chars_left[0]) begin
                                n_nibble_bad = w_hex[4];
                                n_high       = w_hex[3:0];
                            end else if (!r_dropped) begin
                                if (w_byte_idx < {5'd0, w_addr_len}) begin
                                    if (!w_pair_valid) begin
                                        n_dropped = 1'b1;
                                    end else begin
                                        n_addr = w_new_addr;
                                        n_sum  = w_sum_plus;
                                        // Header records must carry a zero address.
                                        if (w_byte_idx == {5'd0, w_addr_len} - 8'd1
                                            && r_type == TYPE_HEADER
                                            && w_new_addr != 32'd0)
                                            n_dropped = 1'b1;
                                    end
                                end else if (r_chars_left == 9'd1) begin
                                    n_emit   = 1'b1;
                                    n_kind   = KIND_DONE;
                                    n_o_cs   = w_pair_valid ? w_pair_byte : 8'd0;
                                    n_o_rd   = w_pair_valid;
                                    n_o_mt   = w_pair_valid && (~r_sum == w_pair_byte);
                                end else if (w_pair_valid) begin
                                    n_sum = w_sum_plus;
                                    if (r_type <= TYPE_LAST_DATA) begin
                                        n_emit     = 1'b1;
                                        n_kind     = KIND_DATA;
                                        n_o_offset = r_data_idx;
                                        n_o_data   = w_pair_byte;
                                        n_data_idx = r_data_idx + 8'd1;
                                    end
                                end
                            end
                            n_chars_left = r_chars_left - 9'd1;
                            if (r_chars_left == 9'd1)
                                n_phase = PH_EOL;
                        end
                    end
                    PH_EOL: begin
                        if (i_char_code == CH_NL)
                            n_phase = PH_START;
                    end
                    default: begin
                        n_phase = PH_START;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_aborted    <= 1'b0;
            r_type       <= 4'd0;
            r_chars_left <= 9'd0;
            r_addr       <= 32'd0;
            r_dropped    <= 1'b0;
            r_high       <= 4'd0;
            r_nibble_bad <= 1'b0;
            r_sum        <= 8'd0;
            r_data_idx   <= 8'd0;
            r_byte_count <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_aborted    <= n_aborted;
            r_type       <= n_type;
            r_chars_left <= n_chars_left;
            r_addr       <= n_addr;
            r_dropped    <= n_dropped;
            r_high       <= n_high;
            r_nibble_bad <= n_nibble_bad;
            r_sum        <= n_sum;
            r_data_idx   <= n_data_idx;
            r_byte_count <= n_byte_count;
            if (o_in_ready)
                r_out_valid <= w_fire && n_emit;
        end
    end

    // Result payload; type and address are the values held before this transfer.
    always_ff @(posedge i_clk) begin
        if (w_fire && n_emit) begin
            r_kind     <= n_kind;
            r_o_type   <= r_type;
            r_o_addr   <= r_addr;
            r_o_offset <= n_o_offset;
            r_o_data   <= n_o_data;
            r_o_cs     <= n_o_cs;
            r_o_rd     <= n_o_rd;
            r_o_mt     <= n_o_mt;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_kind              = r_kind;
    assign o_record_type       = r_o_type;
    assign o_record_address    = r_o_addr;
    assign o_byte_offset       = r_o_offset;
    assign o_data_byte         = r_o_data;
    assign o_checksum_value    = r_o_cs;
    assign o_checksum_readable = r_o_rd;
    assign o_checksum_matches  = r_o_mt;

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_action == ACT_RESTART) |=> (!r_aborted && r_phase == PH_START))
        else $error("restart did not clear parser state");

    a_abort_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_ABORT) |-> r_aborted)
        else $error("abort result without abort flag");

    a_aborted_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_aborted && w_fire && i_action == ACT_CHAR) |=> ($stable(r_phase) && r_aborted))
        else $error("parser moved while aborted");

    a_body_has_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_chars_left != 9'd0))
        else $error("body phase with no characters left");

    a_match_needs_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_mt) |-> (r_o_rd && r_kind == KIND_DONE))
        else $error("checksum match flagged on unreadable checksum");

endmodule
